@@ src/stcd_pkg.sv @@
package stcd_pkg;

  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned SecsPerHour  = 3600;
  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned DaysPerWeek  = 7;
  localparam int unsigned DaysPerYear  = 365;
  localparam int unsigned EpochWeekday = 4;
  localparam int unsigned EpochYearOfs = 70;
  localparam int unsigned EpochMod4    = 2;
  localparam int unsigned EpochMod400  = 370;
  localparam int unsigned LastMonth    = 11;

  localparam int unsigned DayQBits  = 16;
  localparam int unsigned HourQBits = 5;
  localparam int unsigned MinQBits  = 6;
  localparam int unsigned WdayQBits = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_DIV_WDAY,
    ST_YEAR,
    ST_MONTH
  } stcd_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    unique case (month)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3,
      4'd5,
      4'd8,
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ src/seconds_to_calendar_date.sv @@
// Channel     | Handshake            | Payload
// ------------+----------------------+----------------------------------------------
// input       | start & !busy        | in_epoch_seconds
// result      | out_valid (1 cycle)  | out_second_of_minute .. out_day_of_month
//
// One shared 33-bit subtract-and-compare unit does every step: restoring
// division by 86400, 3600, 60 and 7, then one year per cycle from 1970
// and one month per cycle. The year loop sets how long a transaction
// takes. Reset (rst_n, synchronous) returns to idle.
// busy is high for the whole conversion; the result strobe cannot be stalled.
module seconds_to_calendar_date
  import stcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [2:0]  out_weekday,
  output logic [7:0]  out_year_since_1900,
  output logic [8:0]  out_day_of_year,
  output logic [3:0]  out_month_index,
  output logic [4:0]  out_day_of_month
);

  stcd_state_t state_r, state_nxt;

  logic [31:0] acc_r, acc_nxt;
  logic [15:0] q_r, q_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] days_r, days_nxt;
  logic [1:0]  ymod4_r, ymod4_nxt;
  logic [8:0]  ymod400_r, ymod400_nxt;
  logic [7:0]  year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic [8:0]  yday_r, yday_nxt;
  logic [4:0]  mday_r, mday_nxt;
  logic        valid_r, valid_nxt;

  logic [31:0] sub;
  logic [32:0] diff;
  logic        ge;
  logic        leap;
  logic [15:0] q_shift;

  assign leap = (ymod4_r == 2'd0) && (ymod400_r != 9'd100) &&
                (ymod400_r != 9'd200) && (ymod400_r != 9'd300);

  always_comb begin
    sub = 32'd0;
    unique case (state_r)
      ST_DIV_DAY:  sub = SecsPerDay[31:0] << cnt_r;
      ST_DIV_HOUR: sub = SecsPerHour[31:0] << cnt_r;
      ST_DIV_MIN:  sub = SecsPerMin[31:0] << cnt_r;
      ST_DIV_WDAY: sub = DaysPerWeek[31:0] << cnt_r;
      ST_YEAR:     sub = DaysPerYear[31:0] + {31'd0, leap};
      ST_MONTH:    sub = {27'd0, month_len(month_r, leap)};
      default:     sub = 32'd0;
    endcase
  end

  assign diff    = {1'b0, acc_r} - {1'b0, sub};
  assign ge      = ~diff[32];
  assign q_shift = {q_r[14:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    q_r       <= q_nxt;
    cnt_r     <= cnt_nxt;
    days_r    <= days_nxt;
    ymod4_r   <= ymod4_nxt;
    ymod400_r <= ymod400_nxt;
    year_r    <= year_nxt;
    month_r   <= month_nxt;
    second_r  <= second_nxt;
    minute_r  <= minute_nxt;
    hour_r    <= hour_nxt;
    wday_r    <= wday_nxt;
    yday_r    <= yday_nxt;
    mday_r    <= mday_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = 1'b0;
    acc_nxt     = acc_r;
    q_nxt       = q_r;
    cnt_nxt     = cnt_r;
    days_nxt    = days_r;
    ymod4_nxt   = ymod4_r;
    ymod400_nxt = ymod400_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    second_nxt  = second_r;
    minute_nxt  = minute_r;
    hour_nxt    = hour_r;
    wday_nxt    = wday_r;
    yday_nxt    = yday_r;
    mday_nxt    = mday_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          acc_nxt   = in_epoch_seconds;
          q_nxt     = 16'd0;
          cnt_nxt   = 4'(DayQBits - 1);
          state_nxt = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY, ST_DIV_HOUR, ST_DIV_MIN, ST_DIV_WDAY: begin
        if (ge) begin
          acc_nxt = diff[31:0];
        end
        q_nxt   = q_shift;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          q_nxt = 16'd0;
          unique case (state_r)
            ST_DIV_DAY: begin
              days_nxt  = q_shift;
              cnt_nxt   = 4'(HourQBits - 1);
              state_nxt = ST_DIV_HOUR;
            end
            ST_DIV_HOUR: begin
              hour_nxt  = q_shift[4:0];
              cnt_nxt   = 4'(MinQBits - 1);
              state_nxt = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
              minute_nxt = q_shift[5:0];
              second_nxt = acc_nxt[5:0];
              acc_nxt    = {16'd0, days_r} + EpochWeekday[31:0];
              cnt_nxt    = 4'(WdayQBits - 1);
              state_nxt  = ST_DIV_WDAY;
            end
            default: begin
              wday_nxt    = acc_nxt[2:0];
              acc_nxt     = {16'd0, days_r};
              year_nxt    = EpochYearOfs[7:0];
              ymod4_nxt   = EpochMod4[1:0];
              ymod400_nxt = EpochMod400[8:0];
              state_nxt   = ST_YEAR;
            end
          endcase
        end
      end
      ST_YEAR: begin
        if (ge) begin
          acc_nxt     = diff[31:0];
          year_nxt    = year_r + 8'd1;
          ymod4_nxt   = ymod4_r + 2'd1;
          ymod400_nxt = (ymod400_r == 9'd399) ? 9'd0 : ymod400_r + 9'd1;
        end else begin
          yday_nxt  = acc_r[8:0] + 9'd1;
          month_nxt = 4'd0;
          state_nxt = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (ge && (month_r < LastMonth[3:0])) begin
          acc_nxt   = diff[31:0];
          month_nxt = month_r + 4'd1;
        end else begin
          mday_nxt  = acc_r[4:0] + 5'd1;
          valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = valid_r;
  assign out_second_of_minute = second_r;
  assign out_minute_of_hour   = minute_r;
  assign out_hour_of_day      = hour_r;
  assign out_weekday          = wday_r;
  assign out_year_since_1900  = year_r;
  assign out_day_of_year      = yday_r;
  assign out_month_index      = month_r;
  assign out_day_of_month     = mday_r;

endmodule
